// ===== design/tws_pkg.sv =====
package tws_pkg;

   localparam int BLOCK_BYTES_DEFAULT = 512;
   localparam int MAX_RETRIES_DEFAULT = 4;

   typedef enum logic [1:0] {
      CMD_START   = 2'd0,
      CMD_MESSAGE = 2'd1,
      CMD_TICK    = 2'd2,
      CMD_TIMEOUT = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      EV_REQUEST    = 3'd0,
      EV_DATA       = 3'd1,
      EV_RETRANSMIT = 3'd2,
      EV_DONE       = 3'd3,
      EV_ABORT      = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_WAIT = 2'd1
   } phase_type;

   localparam logic [2:0]  OP_REQUEST = 3'd2;
   localparam logic [2:0]  OP_DATA    = 3'd3;
   localparam logic [2:0]  OP_FINAL   = 3'd6;
   localparam logic [15:0] OP_ACK     = 16'd4;

   // Opcode, name terminator, "netascii" with its terminator, and one more byte.
   localparam logic [9:0] REQUEST_OVERHEAD = 10'd13;
   // Data header plus the 32-bit size word of the final block.
   localparam logic [9:0] FINAL_OVERHEAD   = 10'd8;
   localparam logic [9:0] DATA_OVERHEAD    = 10'd4;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [15:0] block_number;
      logic [9:0]  file_bytes;
      logic [9:0]  datagram_length;
   } packet_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [2:0]  opcode;
      logic [15:0] block_number;
      logic [9:0]  file_bytes;
      logic [8:0]  size_word;
      logic [9:0]  datagram_length;
   } result_type;

   // Backoff after the given number of resends: 1, 2, 4, 8, then saturated.
   function automatic logic [3:0] backoff_wait(input logic [2:0] retries);
      logic [3:0] result;
      case (retries)
         3'd1: result = 4'd1;
         3'd2: result = 4'd2;
         3'd3: result = 4'd4;
         3'd4: result = 4'd8;
         default: result = 4'd15;
      endcase
      return result;
   endfunction

endpackage

// ===== design/tws_channels.sv =====
interface tws_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] file_size;
   logic [6:0]  name_length;
   logic [15:0] msg_opcode;
   logic [15:0] msg_block;

   modport source (output valid, output cmd, output file_size, output name_length,
                   output msg_opcode, output msg_block, input ready);
   modport sink (input valid, input cmd, input file_size, input name_length,
                 input msg_opcode, input msg_block, output ready);
endinterface

interface tws_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [2:0]  opcode;
   logic [15:0] block_number;
   logic [9:0]  file_bytes;
   logic [8:0]  size_word;
   logic [9:0]  datagram_length;

   modport source (output valid, output event_res, output opcode, output block_number,
                   output file_bytes, output size_word, output datagram_length,
                   input ready);
   modport sink (input valid, input event_res, input opcode, input block_number,
                 input file_bytes, input size_word, input datagram_length,
                 output ready);
endinterface

// ===== design/tftp_write_sender.sv =====
// Channel    Direction  Transaction
// req_port   in         start, received message, one-second tick or receive timeout
// rsp_port   out        write request, data block, retransmit, done or aborted
//
// One transaction is accepted every cycle while req_port.ready is high; its result,
// if any, is registered and shown on rsp_port in the following cycle.
// req_port.ready drops only while a registered result waits and rsp_port.ready is low.
// Reset is synchronous and returns the session to idle.
// The result passes through a single output register.
module tftp_write_sender #(
   parameter int BLOCK_BYTES = tws_pkg::BLOCK_BYTES_DEFAULT,
   parameter int MAX_RETRIES = tws_pkg::MAX_RETRIES_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   tws_req_if.sink    req_port,
   tws_rsp_if.source  rsp_port
);
   import tws_pkg::*;

   localparam logic [31:0] BLOCK_WORD   = 32'(BLOCK_BYTES);
   localparam logic [9:0]  FULL_BYTES   = 10'(BLOCK_BYTES);
   localparam logic [9:0]  FULL_LENGTH  = 10'(BLOCK_BYTES) + DATA_OVERHEAD;
   localparam logic [2:0]  RETRY_LIMIT  = 3'(MAX_RETRIES);

   phase_type   phase_ff, phase_in;
   logic [15:0] next_block_ff, next_block_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic        final_sent_ff, final_sent_in;
   logic [2:0]  retry_count_ff, retry_count_in;
   logic [3:0]  wait_seconds_ff, wait_seconds_in;
   logic [7:0]  elapsed_ff, elapsed_in;
   packet_type  last_packet_ff, last_packet_in;
   result_type  rsp_data_ff, rsp_data_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        req_accept;
   logic        emit;
   logic        waiting;
   logic        ack_match;
   logic        full_block;
   logic        timeout_due;
   logic        retry_spent;
   logic [2:0]  retry_next;
   logic [9:0]  remainder;

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign req_accept     = req_port.valid && req_port.ready;

   assign waiting     = (phase_ff == PHASE_WAIT);
   assign ack_match   = (req_port.msg_opcode == OP_ACK) &&
                        (req_port.msg_block == next_block_ff - 16'd1);
   assign full_block  = (bytes_left_ff >= BLOCK_WORD);
   assign timeout_due = (elapsed_ff >= {4'd0, wait_seconds_ff});
   assign retry_spent = (retry_count_ff >= RETRY_LIMIT);
   assign retry_next  = retry_count_ff + 3'd1;
   assign remainder   = bytes_left_ff[9:0];

   always_comb begin
      phase_in = phase_ff;
      if (req_accept) begin
         unique case (cmd_type'(req_port.cmd))
            CMD_START: phase_in = PHASE_WAIT;
            CMD_MESSAGE: begin
               if (waiting && ack_match && final_sent_ff) begin
                  phase_in = PHASE_IDLE;
               end
            end
            CMD_TICK: phase_in = phase_ff;
            CMD_TIMEOUT: begin
               if (waiting && timeout_due && retry_spent) begin
                  phase_in = PHASE_IDLE;
               end
            end
         endcase
      end
   end

   always_comb begin
      next_block_in   = next_block_ff;
      bytes_left_in   = bytes_left_ff;
      final_sent_in   = final_sent_ff;
      retry_count_in  = retry_count_ff;
      wait_seconds_in = wait_seconds_ff;
      elapsed_in      = elapsed_ff;
      last_packet_in  = last_packet_ff;
      rsp_data_in     = '0;
      emit            = 1'b0;
      if (req_accept) begin
         unique case (cmd_type'(req_port.cmd))
            CMD_START: begin
               next_block_in   = 16'd1;
               bytes_left_in   = req_port.file_size;
               final_sent_in   = 1'b0;
               retry_count_in  = '0;
               wait_seconds_in = '0;
               elapsed_in      = '0;
               last_packet_in.opcode          = OP_REQUEST;
               last_packet_in.block_number    = '0;
               last_packet_in.file_bytes      = '0;
               last_packet_in.datagram_length = REQUEST_OVERHEAD + {3'd0, req_port.name_length};
               emit                        = 1'b1;
               rsp_data_in.event_res       = EV_REQUEST;
               rsp_data_in.opcode          = OP_REQUEST;
               rsp_data_in.datagram_length = REQUEST_OVERHEAD + {3'd0, req_port.name_length};
            end
            CMD_MESSAGE: begin
               if (waiting && ack_match) begin
                  emit = 1'b1;
                  if (final_sent_ff) begin
                     next_block_in         = 16'd1;
                     bytes_left_in         = '0;
                     final_sent_in         = 1'b0;
                     retry_count_in        = '0;
                     wait_seconds_in       = '0;
                     elapsed_in            = '0;
                     last_packet_in        = '0;
                     rsp_data_in.event_res = EV_DONE;
                  end else begin
                     next_block_in   = next_block_ff + 16'd1;
                     retry_count_in  = '0;
                     wait_seconds_in = '0;
                     elapsed_in      = '0;
                     rsp_data_in.event_res    = EV_DATA;
                     rsp_data_in.block_number = next_block_ff;
                     last_packet_in.block_number = next_block_ff;
                     if (full_block) begin
                        bytes_left_in = bytes_left_ff - BLOCK_WORD;
                        last_packet_in.opcode          = OP_DATA;
                        last_packet_in.file_bytes      = FULL_BYTES;
                        last_packet_in.datagram_length = FULL_LENGTH;
                        rsp_data_in.opcode             = OP_DATA;
                        rsp_data_in.file_bytes         = FULL_BYTES;
                        rsp_data_in.datagram_length    = FULL_LENGTH;
                     end else begin
                        final_sent_in = 1'b1;
                        last_packet_in.opcode          = OP_FINAL;
                        last_packet_in.file_bytes      = remainder;
                        last_packet_in.datagram_length = FINAL_OVERHEAD + remainder;
                        rsp_data_in.opcode             = OP_FINAL;
                        rsp_data_in.file_bytes         = remainder;
                        rsp_data_in.size_word          = remainder[8:0];
                        rsp_data_in.datagram_length    = FINAL_OVERHEAD + remainder;
                     end
                  end
               end
            end
            CMD_TICK: begin
               if (waiting && elapsed_ff != 8'hFF) begin
                  elapsed_in = elapsed_ff + 8'd1;
               end
            end
            CMD_TIMEOUT: begin
               if (waiting && timeout_due) begin
                  emit = 1'b1;
                  if (retry_spent) begin
                     next_block_in         = 16'd1;
                     bytes_left_in         = '0;
                     final_sent_in         = 1'b0;
                     retry_count_in        = '0;
                     wait_seconds_in       = '0;
                     elapsed_in            = '0;
                     last_packet_in        = '0;
                     rsp_data_in.event_res = EV_ABORT;
                  end else begin
                     retry_count_in  = retry_next;
                     wait_seconds_in = backoff_wait(retry_next);
                     elapsed_in      = '0;
                     rsp_data_in.event_res       = EV_RETRANSMIT;
                     rsp_data_in.opcode          = last_packet_ff.opcode;
                     rsp_data_in.block_number    = last_packet_ff.block_number;
                     rsp_data_in.file_bytes      = last_packet_ff.file_bytes;
                     rsp_data_in.datagram_length = last_packet_ff.datagram_length;
                     if (last_packet_ff.opcode == OP_FINAL) begin
                        rsp_data_in.size_word = last_packet_ff.file_bytes[8:0];
                     end
                  end
               end
            end
         endcase
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_IDLE;
         next_block_ff   <= 16'd1;
         bytes_left_ff   <= '0;
         final_sent_ff   <= 1'b0;
         retry_count_ff  <= '0;
         wait_seconds_ff <= '0;
         elapsed_ff      <= '0;
         last_packet_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         next_block_ff   <= next_block_in;
         bytes_left_ff   <= bytes_left_in;
         final_sent_ff   <= final_sent_in;
         retry_count_ff  <= retry_count_in;
         wait_seconds_ff <= wait_seconds_in;
         elapsed_ff      <= elapsed_in;
         last_packet_ff  <= last_packet_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.event_res       = rsp_data_ff.event_res;
   assign rsp_port.opcode          = rsp_data_ff.opcode;
   assign rsp_port.block_number    = rsp_data_ff.block_number;
   assign rsp_port.file_bytes      = rsp_data_ff.file_bytes;
   assign rsp_port.size_word       = rsp_data_ff.size_word;
   assign rsp_port.datagram_length = rsp_data_ff.datagram_length;

   // A start always produces a write request in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_port.cmd == CMD_START
      |=> rsp_valid_ff && rsp_data_ff.event_res == EV_REQUEST)
      else $error("start did not produce a write request");

   // An idle session holds no retry or final-block history.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_IDLE |-> retry_count_ff == 3'd0 && !final_sent_ff)
      else $error("idle session kept stale state");

   // The resend count never passes its limit.
   assert property (@(posedge clock) disable iff (reset)
      retry_count_ff <= RETRY_LIMIT)
      else $error("retry count passed its limit");

   // A result that is not taken keeps the input stalled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_port.ready |-> !req_port.ready)
      else $error("input accepted while a result was stalled");

endmodule
